>>> rtl/char_display_shadow_refresh_macros.svh
// assertion macros shared by the checker of the character display refresh block
`ifndef CHAR_DISPLAY_SHADOW_REFRESH_MACROS_SVH
`define CHAR_DISPLAY_SHADOW_REFRESH_MACROS_SVH

// generic clocked check, off while reset is asserted
`define CDSR_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled request stays valid and keeps its payload
`define CDSR_HOLD(lbl, vld, stl, dat, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> (vld && $stable(dat))) else $error(msg);

`endif

>>> rtl/cdsr_pkg.sv
// types, constants and command structs of the character display refresh block
package cdsr_pkg;

  // panel geometry
  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int CELLS   = ROWS * COLUMNS;

  // request and result field widths
  localparam int ROW_W  = 1;
  localparam int COL_W  = 4;
  localparam int OFS_W  = 5;
  localparam int CHAR_W = 8;

  // internal widths
  localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SCOL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int SROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int POS_MAX = COLUMNS * ((1 << ROW_W) - 1) + ((1 << COL_W) - 1)
                           + ((1 << OFS_W) - 1);
  localparam int POS_A_W = $clog2(POS_MAX + 1);
  localparam int POS_B_W = $clog2(CELLS + 1);
  localparam int POS_W   = (POS_A_W > POS_B_W) ? POS_A_W : POS_B_W;

  // store fill values
  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0] SHADOW_INIT = 8'hFF;

  // request function codes
  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_REFRESH = 2'd1,
    FUNC_FULL    = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [OFS_W-1:0]  char_offset;
    logic [CHAR_W-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_column;
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;
    logic clr_en;
    logic start;
    logic every;
    logic step;
    logic push_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic send_hit;
    logic at_end;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/char_display_shadow_refresh.sv
// Character display refresh: a write request stores one character at
// row*16+column+offset (dropped past cell 31). A refresh, full refresh or
// clear request scans the 32 cells one per cycle while the result side does
// not hold a scan step back, sending each changed (or every) cell and copying
// it into the shadow store; after its accept it scans the cells and then runs
// a final flush, with the input stalled during the scan and the flush. The
// scan rate is set by the single frame/shadow read port walked by the cell
// counter. The last result of a refresh carries last; a changed-cells refresh
// with nothing to send returns no result. After reset the frame holds spaces
// and the shadow 0xFF.
module char_display_shadow_refresh
  import cdsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  cdsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_data.func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  cdsr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/cdsr_ctrl.sv
// controller state machine: request decode, cell scan sequencing, final flush
module cdsr_ctrl
  import cdsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  func_t    in_func,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   every_r, every_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    every_nxt     = every_r;
    cmd           = '0;
    cmd.every     = every_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_WRITE: begin
              cmd.wr_en = 1'b1;
            end
            FUNC_REFRESH: begin
              cmd.start = 1'b1;
              every_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
            FUNC_FULL: begin
              cmd.start = 1'b1;
              every_nxt = 1'b1;
              state_nxt = ST_SCAN;
            end
            FUNC_CLEAR: begin
              cmd.clr_en = 1'b1;
              cmd.start  = 1'b1;
              every_nxt  = 1'b1;
              state_nxt  = ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // a hit with a held cell moves that cell to the output register
        cmd.step = !(stat.send_hit && stat.pend_valid && !stat.out_free);
        if (cmd.step && stat.at_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      every_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      every_r <= every_nxt;
    end
  end

endmodule

>>> rtl/cdsr_dp.sv
// datapath: frame and shadow stores, scan counters, held cell and output register
module cdsr_dp
  import cdsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [CHAR_W-1:0] frame_r  [CELLS];
  logic [CHAR_W-1:0] shadow_r [CELLS];

  logic [IDX_W-1:0]  idx_r;
  logic [SCOL_W-1:0] col_r;
  logic [SROW_W-1:0] row_r;

  out_item_t pend_r;
  logic      pend_valid_r;
  out_item_t out_r;
  logic      out_valid_r;

  logic [POS_W-1:0] wr_pos;
  logic             wr_ok;
  logic             send_hit;
  logic             out_free;
  logic             load_mid;
  logic             load_last;

  // linear write position, dropped past the last cell
  assign wr_pos = (in_data.row != '0 ? POS_W'(COLUMNS) : POS_W'(0))
                + POS_W'(in_data.column) + POS_W'(in_data.char_offset);
  assign wr_ok  = (wr_pos < POS_W'(CELLS));

  // scan cell selection
  assign send_hit  = cmd.every || (frame_r[idx_r] != shadow_r[idx_r]);
  assign out_free  = !out_valid_r || !out_stall;
  assign load_mid  = cmd.step && send_hit && pend_valid_r;
  assign load_last = cmd.push_last;

  assign stat.send_hit   = send_hit;
  assign stat.at_end     = (idx_r == IDX_W'(CELLS - 1));
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = out_free;

  // frame and shadow stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        frame_r[i]  <= SPACE_CHAR;
        shadow_r[i] <= SHADOW_INIT;
      end
    end else begin
      if (cmd.clr_en) begin
        for (int i = 0; i < CELLS; i++) begin
          frame_r[i] <= SPACE_CHAR;
        end
      end else if (cmd.wr_en && wr_ok) begin
        frame_r[wr_pos[IDX_W-1:0]] <= in_data.char_code;
      end
      if (cmd.step && send_hit) begin
        shadow_r[idx_r] <= frame_r[idx_r];
      end
    end
  end

  // scan position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.start) begin
      idx_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      if (col_r == SCOL_W'(COLUMNS - 1)) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // held cell: sent once the next hit or the end of the scan shows its last flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.step && send_hit) begin
      pend_valid_r <= 1'b1;
    end else if (load_last) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && send_hit) begin
      pend_r.out_row    <= ROW_W'(row_r);
      pend_r.out_column <= COL_W'(col_r);
      pend_r.out_char   <= frame_r[idx_r];
      pend_r.last       <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_mid || load_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid) begin
      out_r <= pend_r;
    end else if (load_last) begin
      out_r <= {pend_r.out_row, pend_r.out_column, pend_r.out_char, 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/cdsr_checker.sv
// port-level checker of the character display refresh block and its bind
`include "char_display_shadow_refresh_macros.svh"

module cdsr_checker
  import cdsr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic in_acc;
  logic wr_acc;
  logic scan_acc;

  // accepted request kinds
  assign in_acc   = in_valid && !in_stall;
  assign wr_acc   = in_acc && (in_data.func == FUNC_WRITE);
  assign scan_acc = in_acc && (in_data.func != FUNC_WRITE);

  // a held result keeps its payload
  `CDSR_HOLD(a_out_hold, out_valid, out_stall, out_data, "result changed while stalled")

  // a write request sends nothing
  `CDSR_CHK(a_write_quiet, (wr_acc && !out_valid) |=> !out_valid, "write request sent a result")

  // a refresh request keeps the input stalled while it scans
  `CDSR_CHK(a_scan_busy, scan_acc |=> in_stall, "input open during refresh scan")

  // a result without last means the refresh is still running
  `CDSR_CHK(a_mid_busy, (out_valid && !out_data.last) |-> in_stall, "input open before last result")

endmodule

bind char_display_shadow_refresh cdsr_checker u_cdsr_checker (.*);

>>> tb/char_display_shadow_refresh_tb.sv
// testbench for the character display refresh block: queued requests, cell predictor, checker
module char_display_shadow_refresh_tb;
  import cdsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FLUSH_CYCLES   = 40;
  localparam int QUIET_TAIL     = 40;
  localparam int RANDOM_ITEMS   = 420;
  localparam int PRINT_CAP      = 40;

  // one queued request plus a flag that makes the sender wait for all results first
  typedef struct packed {
    in_item_t req;
    logic     drain;
  } queued_req_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  queued_req_t request_q[$];
  out_item_t   cell_exp_q[$];

  // predicted panel contents
  logic [CHAR_W-1:0] frame_cells  [CELLS];
  logic [CHAR_W-1:0] shadow_cells [CELLS];

  logic req_taken   = 1'b0;
  int   idle_cycles = 0;
  int   err_count   = 0;

  // sender and receiver pacing
  int   in_gap       = 0;
  int   out_gap      = 0;
  int   in_idle_pct  = 16;
  int   out_idle_pct = 16;
  int   phase_cycles = 0;
  logic quiet        = 1'b0;
  logic drv_valid    = 1'b0;

  char_display_shadow_refresh i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic add_request(input func_t f, input int r, input int c, input int ofs,
                             input int code, input bit drain);
    queued_req_t q;
    q.req.func        = f;
    q.req.row         = r[ROW_W-1:0];
    q.req.column      = c[COL_W-1:0];
    q.req.char_offset = ofs[OFS_W-1:0];
    q.req.char_code   = code[CHAR_W-1:0];
    q.drain           = drain;
    request_q.push_back(q);
  endtask

  // update the predicted stores and queue the cells a request sends
  task automatic predict_cells(input in_item_t req);
    int        pos;
    int        cell_row;
    int        cell_col;
    bit        every;
    bit        have_held;
    out_item_t held;
    if (req.func == FUNC_WRITE) begin
      pos = int'(req.row) * COLUMNS + int'(req.column) + int'(req.char_offset);
      if (pos < CELLS) frame_cells[pos] = req.char_code;
    end else begin
      if (req.func == FUNC_CLEAR) begin
        for (int i = 0; i < CELLS; i++) frame_cells[i] = SPACE_CHAR;
      end
      every     = (req.func != FUNC_REFRESH);
      have_held = 1'b0;
      held      = '0;
      for (int i = 0; i < CELLS; i++) begin
        if (every || frame_cells[i] != shadow_cells[i]) begin
          // hold back one cell so the final one can carry last
          if (have_held) cell_exp_q.push_back(held);
          cell_row          = i / COLUMNS;
          cell_col          = i % COLUMNS;
          held.out_row      = cell_row[ROW_W-1:0];
          held.out_column   = cell_col[COL_W-1:0];
          held.out_char     = frame_cells[i];
          held.last         = 1'b0;
          have_held         = 1'b1;
          shadow_cells[i]   = frame_cells[i];
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        cell_exp_q.push_back(held);
      end
    end
  endtask

  task automatic check_cell(input out_item_t got);
    out_item_t want;
    if (cell_exp_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected cell row %0d col %0d char %02h last %0b",
                              got.out_row, got.out_column, got.out_char, got.last));
    end else begin
      want = cell_exp_q.pop_front();
      if (got.out_row !== want.out_row)
        flag_mismatch($sformatf("row %0d, expected %0d", got.out_row, want.out_row));
      if (got.out_column !== want.out_column)
        flag_mismatch($sformatf("column %0d, expected %0d", got.out_column, want.out_column));
      if (got.out_char !== want.out_char)
        flag_mismatch($sformatf("char %02h, expected %02h at row %0d col %0d",
                                got.out_char, want.out_char, want.out_row, want.out_column));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last %0b, expected %0b at row %0d col %0d",
                                got.last, want.last, want.out_row, want.out_column));
    end
  endtask

  // monitor: accept requests and results at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_cells(in_data);
      if (out_valid && !out_stall) check_cell(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // driver: present queued requests and pace the result side at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      phase_cycles++;
      if (phase_cycles % 128 == 0) begin
        in_idle_pct  = $urandom_range(0, 3) * 8;
        out_idle_pct = $urandom_range(0, 3) * 8;
      end
      if (req_taken) request_q.delete(0);
      quiet = (request_q.size() < QUIET_TAIL);
      // no idling at all in the tail of the run
      if (quiet) begin
        in_gap  = 0;
        out_gap = 0;
      end

      // request side
      if (in_valid && !req_taken) begin
        drv_valid = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        drv_valid = 1'b0;
      end else if (request_q.size() == 0) begin
        drv_valid = 1'b0;
      end else if (request_q[0].drain && cell_exp_q.size() != 0) begin
        drv_valid = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
        in_gap    = $urandom_range(0, 15);
        drv_valid = 1'b0;
      end else begin
        drv_valid = 1'b1;
      end
      in_valid <= drv_valid;
      if (drv_valid) in_data <= request_q[0].req;

      // result side
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int kind;
    int len;
    int r;
    int c;
    int code;
    int random_count;

    for (int i = 0; i < CELLS; i++) begin
      frame_cells[i]  = SPACE_CHAR;
      shadow_cells[i] = SHADOW_INIT;
    end

    // directed: every cell differs from the shadow after reset
    add_request(FUNC_REFRESH, 0, 0, 0, 0, 1'b0);
    // nothing changed, with the sender waiting for the full scan to drain
    add_request(FUNC_REFRESH, 1, 15, 31, 255, 1'b1);
    // zero character at the first cell, 0xFF at the last cell
    add_request(FUNC_WRITE, 0, 0, 0, 8'h00, 1'b0);
    add_request(FUNC_WRITE, 1, 15, 0, 8'hFF, 1'b0);
    // largest fields land past the end and are dropped
    add_request(FUNC_WRITE, 1, 15, 31, 8'hAA, 1'b0);
    add_request(FUNC_WRITE, 1, 15, 1, 8'h55, 1'b0);
    // column spill into the next row
    add_request(FUNC_WRITE, 0, 15, 1, 8'h41, 1'b0);
    add_request(FUNC_WRITE, 0, 0, 31, 8'h5A, 1'b0);
    add_request(FUNC_REFRESH, 0, 0, 0, 0, 1'b0);
    add_request(FUNC_FULL, 1, 7, 12, 8'h3C, 1'b0);
    add_request(FUNC_WRITE, 1, 3, 2, 8'h7E, 1'b0);
    add_request(FUNC_WRITE, 0, 8, 0, 8'h80, 1'b0);
    add_request(FUNC_CLEAR, 0, 0, 0, 0, 1'b0);
    // after a clear nothing differs
    add_request(FUNC_REFRESH, 0, 0, 0, 0, 1'b0);
    // writing a space over a space changes nothing
    add_request(FUNC_WRITE, 0, 5, 0, SPACE_CHAR, 1'b0);
    add_request(FUNC_REFRESH, 1, 10, 20, 8'hC3, 1'b0);
    add_request(FUNC_WRITE, 1, 0, 0, 8'h01, 1'b0);
    add_request(FUNC_CLEAR, 1, 15, 31, 255, 1'b0);

    // random: mostly text strings followed by a refresh, plus full, clear and noise
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        r   = $urandom_range(0, 1);
        c   = $urandom_range(0, 15);
        for (int k = 0; k < len; k++) begin
          code = ($urandom_range(0, 3) == 0) ? int'(SPACE_CHAR) : $urandom_range(0, 255);
          add_request(FUNC_WRITE, r, c, k, code, 1'b0);
        end
        add_request(FUNC_REFRESH, $urandom_range(0, 1), $urandom_range(0, 15),
                    $urandom_range(0, 31), $urandom_range(0, 255),
                    $urandom_range(0, 19) == 0);
        random_count += len + 1;
      end else if (kind < 80) begin
        add_request(FUNC_FULL, $urandom_range(0, 1), $urandom_range(0, 15),
                    $urandom_range(0, 31), $urandom_range(0, 255), 1'b0);
        random_count++;
      end else if (kind < 86) begin
        add_request(FUNC_CLEAR, $urandom_range(0, 1), $urandom_range(0, 15),
                    $urandom_range(0, 31), $urandom_range(0, 255), 1'b0);
        random_count++;
      end else begin
        add_request(func_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                    $urandom_range(0, 15), $urandom_range(0, 31),
                    $urandom_range(0, 255), 1'b0);
        random_count++;
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // wait for every request and result, then for any stray cells
    @(negedge clk);
    while ((request_q.size() != 0 || cell_exp_q.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    if (idle_cycles < WATCHDOG_LIMIT) repeat (FLUSH_CYCLES) @(negedge clk);
    if (cell_exp_q.size() != 0)
      flag_mismatch($sformatf("%0d expected cells never arrived", cell_exp_q.size()));

    if (idle_cycles < WATCHDOG_LIMIT && err_count == 0) begin
      $display("char_display_shadow_refresh_tb OK");
    end else begin
      $display("char_display_shadow_refresh_tb NOT OK");
    end
    $finish;
  end

endmodule
